>>> rtl/steering_path_follow_force_defines.svh
// Assertion macros for the path-following steering block.
// Used by the port checker; depends on nothing else.
`ifndef STEERING_PATH_FOLLOW_FORCE_DEFINES_SVH
`define STEERING_PATH_FOLLOW_FORCE_DEFINES_SVH

// Implication checked in the next cycle.
`define SPF_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("steering port check failed");

// Implication checked in the same cycle.
`define SPF_ASSERT_SAME(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("steering port check failed");

`endif

>>> rtl/spf_pkg.sv
// Shared types, constants and helpers for the path-following steering block.
// No dependencies.
package spf_pkg;

  localparam int DATA_W     = 32;
  localparam int DT_W       = 16;
  localparam int OP_W       = 2;
  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int PROD_W     = 2 * DATA_W;
  localparam int DIST_W     = DATA_W + 1;
  localparam int CFG_AW     = 4;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_STEP   = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

  localparam logic [1:0] REG_MAX_SPEED = 2'd0;
  localparam logic [1:0] REG_ARRIVE    = 2'd1;
  localparam logic [1:0] REG_SEEK      = 2'd2;
  localparam logic [1:0] REG_MASS      = 2'd3;

  localparam logic [DATA_W-1:0] RST_MAX_SPEED = 32'd65536;
  localparam logic [DATA_W-1:0] RST_ARRIVE    = 32'd1;
  localparam logic [DATA_W-1:0] RST_SEEK      = 32'd1;
  localparam logic [DATA_W-1:0] RST_MASS      = 32'd65536;

  typedef enum logic [4:0] {
    ST_IDLE, ST_START, ST_RD, ST_DELTA, ST_SQX, ST_SQY, ST_SUM, ST_SQS, ST_CMP,
    ST_ROOT, ST_ROOTW, ST_SPD, ST_SDIV, ST_SDIVW,
    ST_DMX, ST_DDX, ST_DDXW, ST_DMY, ST_DDY, ST_DDYW,
    ST_FX, ST_FMX, ST_FDX, ST_FDXW, ST_FY, ST_FMY, ST_FDY, ST_FDYW, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    MUL_DX2, MUL_DY2, MUL_SEEK2, MUL_ARR, MUL_SDX, MUL_SDY, MUL_FRC
  } mul_sel_t;

  typedef enum logic [1:0] {DIV_ARR, DIV_DIST, DIV_DT} div_sel_t;

  typedef struct packed {
    logic [DATA_W-1:0] max_speed;
    logic [DATA_W-1:0] arrive;
    logic [DATA_W-1:0] seek;
    logic [DATA_W-1:0] mass;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [DATA_W-1:0] point_x;
    logic signed [DATA_W-1:0] point_y;
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
    logic [DT_W-1:0]          time_step;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] force_x;
    logic signed [DATA_W-1:0] force_y;
    logic signed [DATA_W-1:0] desired_x;
    logic signed [DATA_W-1:0] desired_y;
    logic [IDX_W-1:0]         current_index;
    logic                     on_last_point;
    logic                     saturated;
  } out_item_t;

  typedef struct packed {
    logic     clear;
    logic     append;
    logic     capture;
    logic     clamp;
    logic     delta;
    logic     sqx_ld;
    logic     sum_ld;
    logic     idx_inc;
    logic     root_start;
    logic     dist_ld;
    logic     spd_max;
    logic     spd_ld;
    logic     des_zero;
    logic     desx_ld;
    logic     desy_ld;
    logic     fdx;
    logic     fdy;
    logic     fx_ld;
    logic     fy_ld;
    logic     out_ld;
    logic     mul_en;
    logic     div_start;
    mul_sel_t mul_sel;
    div_sel_t div_sel;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic seeking;
    logic seek_hit;
    logic dist_zero;
    logic dist_ge_arr;
    logic root_done;
    logic div_done;
  } sts_t;

  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic              hit;
  } clip_t;

  // Saturate a sign and magnitude to the signed 32-bit range.
  function automatic clip_t clip32(input logic neg, input logic [PROD_W-1:0] mag);
    clip_t r;
    if (neg) begin
      if (mag > PROD_W'(64'h8000_0000)) begin
        r.val = 32'h8000_0000;
        r.hit = 1'b1;
      end else begin
        r.val = DATA_W'(~mag[DATA_W-1:0] + 1'b1);
        r.hit = 1'b0;
      end
    end else begin
      if (mag > PROD_W'(64'h7FFF_FFFF)) begin
        r.val = 32'h7FFF_FFFF;
        r.hit = 1'b1;
      end else begin
        r.val = mag[DATA_W-1:0];
        r.hit = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/spf_channels.sv
// Valid/ready channel interfaces for step/path words and result words.
// Depends on spf_pkg.
interface spf_in_if import spf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [DATA_W-1:0] point_x;
  logic signed [DATA_W-1:0] point_y;
  logic signed [DATA_W-1:0] pos_x;
  logic signed [DATA_W-1:0] pos_y;
  logic signed [DATA_W-1:0] vel_x;
  logic signed [DATA_W-1:0] vel_y;
  logic [DT_W-1:0]          time_step;

  modport source (output valid, operation, point_x, point_y, pos_x, pos_y, vel_x,
                  vel_y, time_step, input ready);
  modport sink (input valid, operation, point_x, point_y, pos_x, pos_y, vel_x,
                vel_y, time_step, output ready);
endinterface

interface spf_out_if import spf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] force_x;
  logic signed [DATA_W-1:0] force_y;
  logic signed [DATA_W-1:0] desired_x;
  logic signed [DATA_W-1:0] desired_y;
  logic [IDX_W-1:0]         current_index;
  logic                     on_last_point;
  logic                     saturated;

  modport source (output valid, force_x, force_y, desired_x, desired_y,
                  current_index, on_last_point, saturated, input ready);
  modport sink (input valid, force_x, force_y, desired_x, desired_y,
                current_index, on_last_point, saturated, output ready);
endinterface

>>> rtl/spf_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
// Depends on spf_pkg.
module spf_div import spf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [DIST_W-1:0] divisor,
  output logic [PROD_W-1:0] quotient,
  output logic              done
);
  localparam int CW = $clog2(PROD_W);

  logic              busy_r, busy_nxt, done_r, done_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [PROD_W-1:0] dvd_r, dvd_nxt;
  logic [DIST_W-1:0] rem_r, rem_nxt, dsr_r, dsr_nxt;
  logic [DIST_W:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    trial    = {rem_r, dvd_r[PROD_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = CW'(PROD_W - 1);
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = DIST_W'(trial - {1'b0, dsr_r});
        dvd_nxt = {dvd_r[PROD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIST_W-1:0];
        dvd_nxt = {dvd_r[PROD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign quotient = dvd_r;
  assign done     = done_r;
endmodule

>>> rtl/spf_sqrt.sv
// Digit-by-digit floor square root of a 66-bit radicand, one root bit per cycle.
// Depends on spf_pkg.
module spf_sqrt import spf_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [PROD_W+1:0]   radicand,
  output logic [DIST_W-1:0]   root,
  output logic                done
);
  localparam int STEPS = DIST_W;
  localparam int CW    = $clog2(STEPS);
  localparam int RW    = DIST_W + 2;

  logic              busy_r, busy_nxt, done_r, done_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [PROD_W+1:0] rad_r, rad_nxt;
  logic [DIST_W-1:0] root_r, root_nxt;
  logic [RW-1:0]     rem_r, rem_nxt;
  logic [RW+1:0]     rem_s, trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    root_nxt = root_r;
    rem_nxt  = rem_r;
    rem_s    = {rem_r, rad_r[PROD_W+1:PROD_W]};
    trial    = (RW+2)'({root_r, 2'b01});
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = CW'(STEPS - 1);
      rad_nxt  = radicand;
      root_nxt = '0;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (rem_s >= trial) begin
        rem_nxt  = RW'(rem_s - trial);
        root_nxt = {root_r[DIST_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_s[RW-1:0];
        root_nxt = {root_r[DIST_W-2:0], 1'b0};
      end
      rad_nxt = {rad_r[PROD_W-1:0], 2'b00};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    root_r <= root_nxt;
    rem_r  <= rem_nxt;
  end

  assign root = root_r;
  assign done = done_r;
endmodule

>>> rtl/spf_dpath.sv
// Datapath: waypoint memory, path index, shared multiplier, divider and root.
// Depends on spf_pkg, spf_div and spf_sqrt.
module spf_dpath import spf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  in_item_t  item,
  input  cmd_t      cmd,
  output sts_t      sts,
  output out_item_t res
);
  logic [DATA_W-1:0] mem_x [MAX_POINTS];
  logic [DATA_W-1:0] mem_y [MAX_POINTS];
  logic [DATA_W-1:0] rd_x_r, rd_y_r;

  logic [CNT_W-1:0]  count_r;
  logic [IDX_W-1:0]  idx_r;
  logic              seeking_r;

  logic signed [DATA_W-1:0] px_r, py_r, vx_r, vy_r;
  logic [DT_W-1:0]   dt_r;
  logic              dxneg_r, dyneg_r, fneg_r;
  logic [DATA_W-1:0] adx_r, ady_r, fmag_r, speed_r;
  logic [PROD_W-1:0] prod_r, sqx_r, sum_r;
  logic              carry_r;
  logic [DIST_W-1:0] dist_r;
  logic [DATA_W-1:0] desx_r, desy_r, fx_r, fy_r;
  logic              fsat_r;
  out_item_t         res_r;

  logic [DATA_W-1:0] mul_a, mul_b;
  logic [DIST_W-1:0] div_dsr, root;
  logic [PROD_W-1:0] quot;
  logic              div_done, root_done;
  logic [DATA_W:0]   dx_w, dy_w, fdiff_x, fdiff_y;
  logic [CNT_W-1:0]  idx_ext;
  clip_t             clip_q;

  assign idx_ext = CNT_W'(idx_r);

  // Waypoint memory: append writes at the fill count, reads track the index.
  always_ff @(posedge clk) begin
    if (cmd.append && count_r < CNT_W'(MAX_POINTS)) begin
      mem_x[count_r[IDX_W-1:0]] <= item.point_x;
      mem_y[count_r[IDX_W-1:0]] <= item.point_y;
    end
    rd_x_r <= mem_x[idx_r];
    rd_y_r <= mem_y[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
    end else if (cmd.clear) begin
      count_r <= '0;
      idx_r   <= '0;
    end else if (cmd.append && count_r < CNT_W'(MAX_POINTS)) begin
      count_r <= count_r + 1'b1;
    end else if (cmd.clamp && count_r != '0 && idx_ext >= count_r) begin
      idx_r <= IDX_W'(count_r - 1'b1);
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_comb begin
    case (cmd.mul_sel)
      MUL_DX2:   begin mul_a = adx_r;          mul_b = adx_r;         end
      MUL_DY2:   begin mul_a = ady_r;          mul_b = ady_r;         end
      MUL_SEEK2: begin mul_a = cfg.seek;       mul_b = cfg.seek;      end
      MUL_ARR:   begin mul_a = dist_r[DATA_W-1:0]; mul_b = cfg.max_speed; end
      MUL_SDX:   begin mul_a = speed_r;        mul_b = adx_r;         end
      MUL_SDY:   begin mul_a = speed_r;        mul_b = ady_r;         end
      MUL_FRC:   begin mul_a = fmag_r;         mul_b = cfg.mass;      end
      default:   begin mul_a = '0;             mul_b = '0;            end
    endcase
  end

  always_comb begin
    case (cmd.div_sel)
      DIV_ARR:  div_dsr = {1'b0, cfg.arrive};
      DIV_DIST: div_dsr = dist_r;
      DIV_DT:   div_dsr = DIST_W'(dt_r);
      default:  div_dsr = '0;
    endcase
  end

  assign dx_w    = {rd_x_r[DATA_W-1], rd_x_r} - {px_r[DATA_W-1], px_r};
  assign dy_w    = {rd_y_r[DATA_W-1], rd_y_r} - {py_r[DATA_W-1], py_r};
  assign fdiff_x = {desx_r[DATA_W-1], desx_r} - {vx_r[DATA_W-1], vx_r};
  assign fdiff_y = {desy_r[DATA_W-1], desy_r} - {vy_r[DATA_W-1], vy_r};

  always_comb begin
    if (cmd.desx_ld)      clip_q = clip32(dxneg_r, quot);
    else if (cmd.desy_ld) clip_q = clip32(dyneg_r, quot);
    else                  clip_q = clip32(fneg_r, quot);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      px_r   <= item.pos_x;
      py_r   <= item.pos_y;
      vx_r   <= item.vel_x;
      vy_r   <= item.vel_y;
      dt_r   <= (item.time_step == '0) ? DT_W'(1) : item.time_step;
      fsat_r <= 1'b0;
    end
    if (cmd.clamp) seeking_r <= (idx_ext + 1'b1) < count_r;
    if (cmd.delta) begin
      dxneg_r <= dx_w[DATA_W];
      dyneg_r <= dy_w[DATA_W];
      adx_r   <= dx_w[DATA_W] ? DATA_W'(-dx_w) : dx_w[DATA_W-1:0];
      ady_r   <= dy_w[DATA_W] ? DATA_W'(-dy_w) : dy_w[DATA_W-1:0];
    end
    if (cmd.mul_en)  prod_r <= mul_a * mul_b;
    if (cmd.sqx_ld)  sqx_r <= prod_r;
    if (cmd.sum_ld)  {carry_r, sum_r} <= {1'b0, sqx_r} + {1'b0, prod_r};
    if (cmd.dist_ld) dist_r <= root;
    if (cmd.spd_max) speed_r <= cfg.max_speed;
    if (cmd.spd_ld)  speed_r <= quot[DATA_W-1:0];
    if (cmd.des_zero) begin
      desx_r <= '0;
      desy_r <= '0;
    end
    if (cmd.desx_ld) desx_r <= clip_q.val;
    if (cmd.desy_ld) desy_r <= clip_q.val;
    if (cmd.fdx) begin
      fneg_r <= fdiff_x[DATA_W];
      fmag_r <= fdiff_x[DATA_W] ? DATA_W'(-fdiff_x) : fdiff_x[DATA_W-1:0];
    end
    if (cmd.fdy) begin
      fneg_r <= fdiff_y[DATA_W];
      fmag_r <= fdiff_y[DATA_W] ? DATA_W'(-fdiff_y) : fdiff_y[DATA_W-1:0];
    end
    if (cmd.fx_ld) begin
      fx_r   <= clip_q.val;
      fsat_r <= fsat_r | clip_q.hit;
    end
    if (cmd.fy_ld) begin
      fy_r   <= clip_q.val;
      fsat_r <= fsat_r | clip_q.hit;
    end
    if (cmd.out_ld) begin
      res_r.force_x       <= fx_r;
      res_r.force_y       <= fy_r;
      res_r.desired_x     <= desx_r;
      res_r.desired_y     <= desy_r;
      res_r.current_index <= idx_r;
      res_r.on_last_point <= (count_r != '0) && ((idx_ext + 1'b1) >= count_r);
      res_r.saturated     <= fsat_r;
    end
  end

  spf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_r),
    .divisor  (div_dsr),
    .quotient (quot),
    .done     (div_done)
  );

  spf_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.root_start),
    .radicand ({1'b0, carry_r, sum_r}),
    .root     (root),
    .done     (root_done)
  );

  assign sts.count_zero  = (count_r == '0);
  assign sts.seeking     = seeking_r;
  assign sts.seek_hit    = !carry_r && (sum_r < prod_r);
  assign sts.dist_zero   = (dist_r == '0);
  assign sts.dist_ge_arr = dist_r >= {1'b0, cfg.arrive};
  assign sts.root_done   = root_done;
  assign sts.div_done    = div_done;

  assign res = res_r;
endmodule

>>> rtl/spf_ctrl.sv
// Controller state machine: sequences one word at a time through the datapath.
// Depends on spf_pkg.
module spf_ctrl import spf_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [OP_W-1:0] in_op,
  input  logic            out_ready,
  input  sts_t            sts,
  output cmd_t            cmd,
  output logic            in_ready,
  output logic            out_valid
);
  state_t state_r, state_nxt;
  logic   pass2_r, pass2_nxt;
  logic   outv_r, outv_nxt;
  logic   slot_free;

  assign slot_free = !outv_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    pass2_nxt = pass2_r;
    case (state_r)
      ST_IDLE:  if (in_valid && in_op == OP_STEP) state_nxt = ST_START;
      ST_START: begin
        pass2_nxt = 1'b0;
        state_nxt = sts.count_zero ? ST_FX : ST_RD;
      end
      ST_RD:    state_nxt = ST_DELTA;
      ST_DELTA: state_nxt = ST_SQX;
      ST_SQX:   state_nxt = ST_SQY;
      ST_SQY:   state_nxt = ST_SUM;
      ST_SUM:   state_nxt = (sts.seeking && !pass2_r) ? ST_SQS : ST_ROOT;
      ST_SQS:   state_nxt = ST_CMP;
      ST_CMP: begin
        if (sts.seek_hit) begin
          pass2_nxt = 1'b1;
          state_nxt = ST_RD;
        end else begin
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT:  state_nxt = ST_ROOTW;
      ST_ROOTW: if (sts.root_done) state_nxt = ST_SPD;
      ST_SPD: begin
        if (sts.dist_zero) state_nxt = ST_FX;
        else if (sts.seeking || sts.dist_ge_arr) state_nxt = ST_DMX;
        else state_nxt = ST_SDIV;
      end
      ST_SDIV:  state_nxt = ST_SDIVW;
      ST_SDIVW: if (sts.div_done) state_nxt = ST_DMX;
      ST_DMX:   state_nxt = ST_DDX;
      ST_DDX:   state_nxt = ST_DDXW;
      ST_DDXW:  if (sts.div_done) state_nxt = ST_DMY;
      ST_DMY:   state_nxt = ST_DDY;
      ST_DDY:   state_nxt = ST_DDYW;
      ST_DDYW:  if (sts.div_done) state_nxt = ST_FX;
      ST_FX:    state_nxt = ST_FMX;
      ST_FMX:   state_nxt = ST_FDX;
      ST_FDX:   state_nxt = ST_FDXW;
      ST_FDXW:  if (sts.div_done) state_nxt = ST_FY;
      ST_FY:    state_nxt = ST_FMY;
      ST_FMY:   state_nxt = ST_FDY;
      ST_FDY:   state_nxt = ST_FDYW;
      ST_FDYW:  if (sts.div_done) state_nxt = ST_DONE;
      ST_DONE:  if (slot_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.mul_sel = MUL_DX2;
    cmd.div_sel = DIV_DT;
    in_ready    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.clear   = in_valid && in_op == OP_CLEAR;
        cmd.append  = in_valid && in_op == OP_APPEND;
        cmd.capture = in_valid && in_op == OP_STEP;
      end
      ST_START: begin
        cmd.clamp    = 1'b1;
        cmd.des_zero = sts.count_zero;
      end
      ST_DELTA: cmd.delta = 1'b1;
      ST_SQX: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DX2;
      end
      ST_SQY: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DY2;
        cmd.sqx_ld  = 1'b1;
      end
      ST_SUM:   cmd.sum_ld = 1'b1;
      ST_SQS: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SEEK2;
      end
      ST_CMP:   cmd.idx_inc = sts.seek_hit;
      ST_ROOT:  cmd.root_start = 1'b1;
      ST_ROOTW: cmd.dist_ld = sts.root_done;
      ST_SPD: begin
        cmd.des_zero = sts.dist_zero;
        cmd.spd_max  = sts.seeking || sts.dist_ge_arr;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_ARR;
      end
      ST_SDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_ARR;
      end
      ST_SDIVW: cmd.spd_ld = sts.div_done;
      ST_DMX: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SDX;
      end
      ST_DDX: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_DIST;
      end
      ST_DDXW: cmd.desx_ld = sts.div_done;
      ST_DMY: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SDY;
      end
      ST_DDY: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_DIST;
      end
      ST_DDYW: cmd.desy_ld = sts.div_done;
      ST_FX:   cmd.fdx = 1'b1;
      ST_FMX, ST_FMY: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_FRC;
      end
      ST_FDX, ST_FDY: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_DT;
      end
      ST_FDXW: cmd.fx_ld = sts.div_done;
      ST_FY:   cmd.fdy = 1'b1;
      ST_FDYW: cmd.fy_ld = sts.div_done;
      ST_DONE: cmd.out_ld = slot_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    outv_nxt = outv_r;
    if (cmd.out_ld)     outv_nxt = 1'b1;
    else if (out_ready) outv_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pass2_r <= 1'b0;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass2_r <= pass2_nxt;
      outv_r  <= outv_nxt;
    end
  end

  assign out_valid = outv_r;
endmodule

>>> rtl/steering_path_follow_force.sv
// Path-following steering force: a step word runs through the serial divider
// (two to five divisions per step) and, when the path is not empty, the square
// root before its result is valid. One step is in flight at a time; a finished
// result waits in the output register while the next word is accepted.
// Synchronous active-low reset clears the path count and index and the
// sequencer, and loads the config registers with their reset values.
module steering_path_follow_force import spf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  spf_in_if.sink            in_ch,
  spf_out_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);
  cfg_t      cfg_r;
  in_item_t  item;
  out_item_t res;
  cmd_t      cmd;
  sts_t      sts;
  logic      cfg_we;

  // Config registers: write on the APB access phase, zero-wait.
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_speed <= RST_MAX_SPEED;
      cfg_r.arrive    <= RST_ARRIVE;
      cfg_r.seek      <= RST_SEEK;
      cfg_r.mass      <= RST_MASS;
    end else if (cfg_we) begin
      case (cfg_paddr[3:2])
        REG_MAX_SPEED: cfg_r.max_speed <= cfg_pwdata;
        REG_ARRIVE:    cfg_r.arrive    <= cfg_pwdata;
        REG_SEEK:      cfg_r.seek      <= cfg_pwdata;
        REG_MASS:      cfg_r.mass      <= cfg_pwdata;
        default:       cfg_r.mass      <= cfg_r.mass;
      endcase
    end
  end

  // Readback of the register selected by the word address.
  always_comb begin
    case (cfg_paddr[3:2])
      REG_MAX_SPEED: cfg_prdata = cfg_r.max_speed;
      REG_ARRIVE:    cfg_prdata = cfg_r.arrive;
      REG_SEEK:      cfg_prdata = cfg_r.seek;
      REG_MASS:      cfg_prdata = cfg_r.mass;
      default:       cfg_prdata = '0;
    endcase
  end

  // Gather the input word into one struct for the datapath.
  assign item.operation = in_ch.operation;
  assign item.point_x   = in_ch.point_x;
  assign item.point_y   = in_ch.point_y;
  assign item.pos_x     = in_ch.pos_x;
  assign item.pos_y     = in_ch.pos_y;
  assign item.vel_x     = in_ch.vel_x;
  assign item.vel_y     = in_ch.vel_y;
  assign item.time_step = in_ch.time_step;

  spf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.operation),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid)
  );

  spf_dpath u_dpath (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .item  (item),
    .cmd   (cmd),
    .sts   (sts),
    .res   (res)
  );

  // Drive the result word from the datapath's output register.
  assign out_ch.force_x       = res.force_x;
  assign out_ch.force_y       = res.force_y;
  assign out_ch.desired_x     = res.desired_x;
  assign out_ch.desired_y     = res.desired_y;
  assign out_ch.current_index = res.current_index;
  assign out_ch.on_last_point = res.on_last_point;
  assign out_ch.saturated     = res.saturated;
endmodule

>>> rtl/spf_checker.sv
// Port-level checker for the steering block, bound to the top level.
// Depends on spf_pkg and steering_path_follow_force_defines.svh.
`include "steering_path_follow_force_defines.svh"

module spf_checker import spf_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [OP_W-1:0]   in_operation,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] out_force_x,
  input logic [DATA_W-1:0] out_desired_x
);
  `SPF_ASSERT_NEXT(a_step_blocks, clk, rst_n, in_valid && in_ready && in_operation == OP_STEP, !in_ready)
  `SPF_ASSERT_SAME(a_done_frees_input, clk, rst_n, $rose(out_valid), in_ready)
  `SPF_ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid && !out_ready, out_valid)
  `SPF_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_force_x) && $stable(out_desired_x))
endmodule

bind steering_path_follow_force spf_checker u_spf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_operation  (in_ch.operation),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_force_x   (out_ch.force_x),
  .out_desired_x (out_ch.desired_x)
);

>>> test/spf_checker.sv
// Result checker for the path-following steering block: watches the step and
// result channels, predicts each result word and compares it field by field.
// Depends on spf_pkg and the channel interfaces in rtl/spf_channels.sv.
module spf_scoreboard import spf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  spf_in_if                  in_ch,
  spf_out_if                 out_ch,
  input  logic               cfg_wr,
  input  logic [1:0]         cfg_reg,
  input  logic [DATA_W-1:0]  cfg_val,
  output int                 fail_count,
  output int                 pending
);

  logic [DATA_W-1:0] path_x [MAX_POINTS];
  logic [DATA_W-1:0] path_y [MAX_POINTS];
  int unsigned       path_len;
  int unsigned       path_pos;
  logic [63:0]       top_speed, slow_radius, reach_radius, mass;
  out_item_t         expected_q[$];

  assign pending = expected_q.size();

  function automatic logic [63:0] mag_of(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [DATA_W-1:0] sat32(input logic neg, input logic [63:0] m,
                                              inout logic hit);
    if (neg) begin
      if (m > 64'h8000_0000) begin
        hit = 1'b1;
        return 32'h8000_0000;
      end
      return DATA_W'(-m);
    end
    if (m > 64'h7FFF_FFFF) begin
      hit = 1'b1;
      return 32'h7FFF_FFFF;
    end
    return m[31:0];
  endfunction

  // Floor square root of a 66-bit value, two bits per iteration.
  function automatic logic [63:0] root66(input logic [65:0] v);
    logic [67:0] rem;
    logic [67:0] trial;
    logic [63:0] root;
    rem = '0;
    root = '0;
    for (int i = 32; i >= 0; i--) begin
      rem = (rem << 2) | 68'(v[2*i +: 2]);
      trial = {root, 2'b01};
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic logic [65:0] dist_sq(input int unsigned k, input logic signed [63:0] px,
                                          input logic signed [63:0] py,
                                          output logic signed [63:0] dx,
                                          output logic signed [63:0] dy);
    dx = 64'(signed'(path_x[k])) - px;
    dy = 64'(signed'(path_y[k])) - py;
    return 66'(mag_of(dx)) * 66'(mag_of(dx)) + 66'(mag_of(dy)) * 66'(mag_of(dy));
  endfunction

  function automatic logic [DATA_W-1:0] force_of(input logic [DATA_W-1:0] want,
                                                 input logic signed [63:0] vel,
                                                 input logic [63:0] dt, inout logic hit);
    logic signed [63:0] diff;
    logic [95:0]        m;
    diff = 64'(signed'(want)) - vel;
    m = 96'(mag_of(diff)) * 96'(mass) / 96'(dt);
    return sat32(diff < 0, m > 96'hFFFF_FFFF_FFFF ? 64'hFFFF_FFFF_FFFF : m[63:0], hit);
  endfunction

  task automatic predict_step(input in_item_t w);
    out_item_t          r;
    logic signed [63:0] px, py, dx, dy;
    logic [63:0]        dt, span, speed;
    logic [65:0]        sq;
    logic               seeking, dhit, fhit;
    r = '0;
    dhit = 0;
    fhit = 0;
    px = 64'(w.pos_x);
    py = 64'(w.pos_y);
    dt = w.time_step == 0 ? 64'd1 : 64'(w.time_step);
    if (path_len > 0) begin
      seeking = path_pos + 1 < path_len;
      if (path_pos >= path_len) path_pos = path_len - 1;
      if (seeking) begin
        sq = dist_sq(path_pos, px, py, dx, dy);
        if (sq < 66'(reach_radius * reach_radius)) path_pos++;
      end
      sq = dist_sq(path_pos, px, py, dx, dy);
      span = root66(sq);
      if (span != 0) begin
        if (seeking || span >= slow_radius) speed = top_speed;
        else speed = 64'(96'(span) * 96'(top_speed) / 96'(slow_radius));
        r.desired_x = sat32(dx < 0, 64'(128'(speed) * 128'(mag_of(dx)) / 128'(span)), dhit);
        r.desired_y = sat32(dy < 0, 64'(128'(speed) * 128'(mag_of(dy)) / 128'(span)), dhit);
      end
      r.on_last_point = path_pos + 1 >= path_len;
    end
    r.force_x = force_of(r.desired_x, 64'(w.vel_x), dt, fhit);
    r.force_y = force_of(r.desired_y, 64'(w.vel_y), dt, fhit);
    r.current_index = path_pos[IDX_W-1:0];
    r.saturated = fhit;
    expected_q.push_back(r);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      path_len <= 0;
      path_pos <= 0;
      top_speed <= 64'(RST_MAX_SPEED);
      slow_radius <= 64'(RST_ARRIVE);
      reach_radius <= 64'(RST_SEEK);
      mass <= 64'(RST_MASS);
      fail_count <= 0;
      expected_q.delete();
    end else begin
      if (cfg_wr) begin
        case (cfg_reg)
          REG_MAX_SPEED: top_speed <= 64'(cfg_val);
          REG_ARRIVE: slow_radius <= 64'(cfg_val);
          REG_SEEK: reach_radius <= 64'(cfg_val);
          default: mass <= 64'(cfg_val);
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        in_item_t w;
        w = '{in_ch.operation, in_ch.point_x, in_ch.point_y, in_ch.pos_x, in_ch.pos_y,
              in_ch.vel_x, in_ch.vel_y, in_ch.time_step};
        case (w.operation)
          OP_CLEAR: begin
            path_len = 0;
            path_pos = 0;
          end
          OP_APPEND: begin
            if (path_len < MAX_POINTS) begin
              path_x[path_len] = w.point_x;
              path_y[path_len] = w.point_y;
              path_len++;
            end
          end
          OP_STEP: predict_step(w);
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        out_item_t e;
        if (expected_q.size() == 0) begin
          $error("result word with no step waiting");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (out_ch.force_x !== e.force_x ||
              out_ch.force_y !== e.force_y ||
              out_ch.desired_x !== e.desired_x ||
              out_ch.desired_y !== e.desired_y ||
              out_ch.current_index !== e.current_index ||
              out_ch.on_last_point !== e.on_last_point ||
              out_ch.saturated !== e.saturated) begin
            if (out_ch.force_x !== e.force_x)
              $error("force_x exp %h got %h", e.force_x, out_ch.force_x);
            if (out_ch.force_y !== e.force_y)
              $error("force_y exp %h got %h", e.force_y, out_ch.force_y);
            if (out_ch.desired_x !== e.desired_x)
              $error("desired_x exp %h got %h", e.desired_x, out_ch.desired_x);
            if (out_ch.desired_y !== e.desired_y)
              $error("desired_y exp %h got %h", e.desired_y, out_ch.desired_y);
            if (out_ch.current_index !== e.current_index)
              $error("current_index exp %0d got %0d", e.current_index,
                     out_ch.current_index);
            if (out_ch.on_last_point !== e.on_last_point)
              $error("on_last_point exp %b got %b", e.on_last_point,
                     out_ch.on_last_point);
            if (out_ch.saturated !== e.saturated)
              $error("saturated exp %b got %b", e.saturated, out_ch.saturated);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

>>> test/testbench.sv
// Top of the path-following steering testbench: builds path and step words,
// programs the config registers between phases and gives the verdict.
// Depends on spf_pkg, rtl/spf_channels.sv, spf_scoreboard and the block itself.
module testbench;
  import spf_pkg::*;

  localparam int QUIET_LIMIT = 20000;   // cycles with no word moving
  localparam int DRAIN_WAIT  = 400;     // idle wait after the results drain

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [DATA_W-1:0] cfg_pwdata, cfg_prdata;
  int   fail_count, pending, quiet, path_fill;

  spf_in_if  in_ch ();
  spf_out_if out_ch ();

  steering_path_follow_force dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  spf_scoreboard chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_wr(cfg_psel && cfg_penable && cfg_pwrite && cfg_pready),
    .cfg_reg(cfg_paddr[3:2]), .cfg_val(cfg_pwdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run when no word moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        cfg_psel) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Result side: draw a stall for each word, sometimes none at all.
  initial begin
    int stall;
    out_ch.ready = 0;
    @(negedge clk);
    while (1) begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      repeat (stall) @(negedge clk);
      out_ch.ready = 1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
      out_ch.ready = 0;
    end
  end

  task automatic cfg_write(input logic [1:0] which, input logic [DATA_W-1:0] value);
    cfg_paddr = {which, 2'b00};
    cfg_pwdata = value;
    cfg_pwrite = 1;
    cfg_psel = 1;
    @(negedge clk);
    cfg_penable = 1;
    @(negedge clk);
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
  endtask

  // Hand one word to the block after a random gap; hold it until taken.
  task automatic send(input logic [OP_W-1:0] op, input logic [31:0] ax, input logic [31:0] ay,
                      input logic [31:0] vx, input logic [31:0] vy,
                      input logic [DT_W-1:0] dt);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
    repeat (gap) @(negedge clk);
    in_ch.operation = op;
    in_ch.point_x = ax;
    in_ch.point_y = ay;
    in_ch.pos_x = ax;
    in_ch.pos_y = ay;
    in_ch.vel_x = vx;
    in_ch.vel_y = vy;
    in_ch.time_step = dt;
    in_ch.valid = 1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    in_ch.valid = 0;
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return 32'($signed($urandom_range(0, 40000)) - 20000);
    endcase
  endfunction

  function automatic logic [DT_W-1:0] rnd_dt();
    return ($urandom_range(0, 4) == 0) ? DT_W'($urandom) : DT_W'($urandom_range(1, 65535));
  endfunction

  // Idle the block: drain expected results, then cover a trailing step.
  task automatic settle();
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic step_rand();
    send(OP_STEP, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_dt());
  endtask

  initial begin
    logic [31:0] wx, wy;
    rst_n = 0;
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_ch.valid = 0;
    in_ch.operation = OP_CLEAR;
    in_ch.point_x = 0;
    in_ch.point_y = 0;
    in_ch.pos_x = 0;
    in_ch.pos_y = 0;
    in_ch.vel_x = 0;
    in_ch.vel_y = 0;
    in_ch.time_step = 1;
    path_fill = 0;
    repeat (6) @(negedge clk);
    rst_n = 1;

    // Directed: empty path, extremes of velocity, zero and full time step.
    send(OP_STEP, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 16'd1);
    send(OP_STEP, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 16'd0);
    send(OP_STEP, 0, 0, 32'h0001_0000, 32'hFFFF_0000, 16'hFFFF);
    send(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    // Two points far apart; stand on the first, then on the last (zero distance).
    send(OP_APPEND, 32'h8000_0000, 32'h8000_0000, 0, 0, 1);
    send(OP_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 1);
    send(OP_STEP, 32'h8000_0000, 32'h8000_0000, 0, 0, 16'h8000);
    send(OP_STEP, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1234_5678, 0, 16'h10);
    send(OP_STEP, 0, 0, 0, 0, 16'h100);
    send(OP_CLEAR, 0, 0, 0, 0, 1);
    // Fill the store past its end: the last append is dropped.
    for (int i = 0; i <= MAX_POINTS; i++)
      send(OP_APPEND, 32'(i) << 16, 32'(-i) << 16, 0, 0, 1);
    send(OP_STEP, 32'h0004_0000, 0, 0, 0, 16'h4000);
    send(OP_CLEAR, 0, 0, 0, 0, 1);

    // Random phases, each under its own register setting, extremes included.
    for (int phase = 0; phase < 8; phase++) begin
      settle();
      case (phase)
        0: begin
          cfg_write(REG_MAX_SPEED, 32'hFFFF_FFFF); cfg_write(REG_ARRIVE, 32'hFFFF_FFFF);
          cfg_write(REG_SEEK, 32'hFFFF_FFFF); cfg_write(REG_MASS, 32'hFFFF_FFFF);
        end
        1: begin
          cfg_write(REG_MAX_SPEED, 0); cfg_write(REG_ARRIVE, 0);
          cfg_write(REG_SEEK, 0); cfg_write(REG_MASS, 0);
        end
        2: begin
          cfg_write(REG_MAX_SPEED, 32'h0002_0000); cfg_write(REG_ARRIVE, 32'h0008_0000);
          cfg_write(REG_SEEK, 32'h0000_8000); cfg_write(REG_MASS, 32'h0001_0000);
        end
        default: begin
          cfg_write(REG_MAX_SPEED, $urandom); cfg_write(REG_ARRIVE, $urandom_range(1, 2000000));
          cfg_write(REG_SEEK, $urandom_range(0, 200000)); cfg_write(REG_MASS, $urandom);
        end
      endcase
      // Mostly well-formed paths followed by walks along them, some noise.
      for (int n = 0; n < 210; ) begin
        case ($urandom_range(0, 9))
          0: begin
            send(OP_CLEAR, 0, 0, 0, 0, 1);
            path_fill = 0;
            n++;
          end
          1, 2: begin
            if (path_fill < MAX_POINTS) path_fill++;
            send(OP_APPEND, rnd_coord(), rnd_coord(), 0, 0, 1);
            n++;
          end
          3: begin
            send(OP_NOP, $urandom, $urandom, $urandom, $urandom, rnd_dt());
          end
          default: begin
            // Half the time walk near the origin, where many waypoints lie, so the index can advance.
            wx = 32'($signed($urandom_range(0, 600)) - 300) << 8;
            wy = 32'($signed($urandom_range(0, 600)) - 300) << 8;
            if ($urandom_range(0, 1)) step_rand();
            else send(OP_STEP, wx, wy, rnd_coord(), rnd_coord(), rnd_dt());
            n++;
          end
        endcase
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/spf_pkg.sv
rtl/spf_channels.sv
rtl/spf_div.sv
rtl/spf_sqrt.sv
rtl/spf_dpath.sv
rtl/spf_ctrl.sv
rtl/steering_path_follow_force.sv
rtl/spf_checker.sv
test/spf_checker.sv
test/testbench.sv
